[rtl/gbs_pkg.sv]
// Shared types and constants for the greedy box suppression block.
// No dependencies.
`default_nettype none
package gbs_pkg;

  localparam int unsigned MaxCandidates = 32;
  localparam int unsigned MaxKept       = 8;
  localparam logic [15:0] IouThrReset   = 16'd32768;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_span_x;
    logic [15:0] box_span_y;
    logic [15:0] box_score;
    logic        box_present;
    logic        frame_end;
  } box_in_t;

  typedef struct packed {
    logic [15:0] kept_left;
    logic [15:0] kept_top;
    logic [15:0] kept_span_x;
    logic [15:0] kept_span_y;
    logic [15:0] kept_score;
    logic        person_found;
    logic        last_result;
  } box_out_t;

  // geom packing: {span_y, span_x, top, left}
  typedef struct packed {
    logic        store;
    logic        frame_end;
    logic [15:0] score;
    logic [63:0] geom;
  } cand_t;

endpackage
`default_nettype wire

[rtl/greedy_box_suppression.sv]
// Top level of the greedy box suppression block.
// Depends on gbs_pkg, gbs_front, gbs_fifo, gbs_back.
//
// Boxes stream in at one item per cycle, while the two-entry queue has
// room, into that queue and are written to the candidate RAM; the first
// MAX_CANDIDATES boxes of a frame are kept, further ones dropped. On the
// frame-end item the back end picks candidates in score order (ties in
// arrival order), one pick per scan of the RAM through its single read
// port, then tests the pick against each kept box in the five-stage
// overlap unit. Inputs stall meanwhile once the queue fills. The threshold
// register may only be written while idle.
`default_nettype none
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = MaxCandidates,
  parameter int unsigned MAX_KEPT       = MaxKept
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire box_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output box_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i
);
  logic [15:0] thr_q;
  logic        q_full, q_push, q_valid, q_pop;
  cand_t       q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= IouThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  gbs_front #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  gbs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_out)
  );

  gbs_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .MAX_KEPT       (MAX_KEPT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_out),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire

[rtl/gbs_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module gbs_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/gbs_fifo.sv]
// Two-entry queue of classified candidates between front and back.
// Depends on gbs_pkg.
`default_nettype none
module gbs_fifo
  import gbs_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cand_t push_data_i,
  output logic       full_o,
  output logic       pop_valid_o,
  input  wire logic  pop_i,
  output cand_t      pop_data_o
);
  cand_t      mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wp_d  = wp_q ^ do_push;
    rp_d  = rp_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end
endmodule
`default_nettype wire

[rtl/gbs_front.sv]
// Front end: accepts items, drops empty ones and boxes past capacity.
// Depends on gbs_pkg.
`default_nettype none
module gbs_front
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = MaxCandidates
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire box_in_t in_data_i,
  input  wire logic    q_full_i,
  output logic         q_push_o,
  output cand_t        q_data_o
);
  localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);

  logic [CW-1:0] fc_q, fc_d;
  logic          acc, room;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign room       = (fc_q < CW'(MAX_CANDIDATES));

  always_comb begin
    q_data_o.store     = in_data_i.box_present && room;
    q_data_o.frame_end = in_data_i.frame_end;
    q_data_o.score     = in_data_i.box_score;
    q_data_o.geom      = {in_data_i.box_span_y, in_data_i.box_span_x,
                          in_data_i.box_top, in_data_i.box_left};
    q_push_o = acc && (q_data_o.store || in_data_i.frame_end);
    fc_d = fc_q;
    if (acc) begin
      if (in_data_i.frame_end) begin
        fc_d = '0;
      end else if (q_data_o.store) begin
        fc_d = fc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
    end else begin
      fc_q <= fc_d;
    end
  end
endmodule
`default_nettype wire

[rtl/gbs_iou.sv]
// Five-stage overlap test: intersection*65536 >= threshold*union
// or, for a zero union, threshold == 0. No dependencies.
`default_nettype none
module gbs_iou (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  input  wire logic [15:0] thr_i,
  output logic             done_o,
  output logic             hit_o
);
  logic [4:0]  v_q;
  logic [15:0] iw_q, ih_q, aw_q, ah_q, bw_q, bh_q;
  logic [31:0] inter2_q, area_a_q, area_b_q;
  logic [31:0] inter3_q;
  logic [32:0] uni_q;
  logic [48:0] prod_q;
  logic [47:0] ish_q;
  logic        zero_q;
  logic        hit_q;

  logic [15:0] lft, tp;
  logic [16:0] ar, br, ab, bb, rgt, bot;
  logic [16:0] iw, ih;

  always_comb begin
    lft = (a_i[15:0] > b_i[15:0]) ? a_i[15:0] : b_i[15:0];
    tp  = (a_i[31:16] > b_i[31:16]) ? a_i[31:16] : b_i[31:16];
    ar  = {1'b0, a_i[15:0]} + {1'b0, a_i[47:32]};
    br  = {1'b0, b_i[15:0]} + {1'b0, b_i[47:32]};
    ab  = {1'b0, a_i[31:16]} + {1'b0, a_i[63:48]};
    bb  = {1'b0, b_i[31:16]} + {1'b0, b_i[63:48]};
    rgt = (ar < br) ? ar : br;
    bot = (ab < bb) ? ab : bb;
    iw  = (rgt > {1'b0, lft}) ? rgt - {1'b0, lft} : 17'd0;
    ih  = (bot > {1'b0, tp}) ? bot - {1'b0, tp} : 17'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    iw_q     <= iw[15:0];
    ih_q     <= ih[15:0];
    aw_q     <= a_i[47:32];
    ah_q     <= a_i[63:48];
    bw_q     <= b_i[47:32];
    bh_q     <= b_i[63:48];
    inter2_q <= iw_q * ih_q;
    area_a_q <= aw_q * ah_q;
    area_b_q <= bw_q * bh_q;
    inter3_q <= inter2_q;
    uni_q    <= {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter2_q};
    prod_q   <= thr_i * uni_q;
    ish_q    <= {inter3_q, 16'd0};
    zero_q   <= (uni_q == '0);
    hit_q    <= zero_q ? (thr_i == 16'd0) : ({1'b0, ish_q} >= prod_q);
  end

  assign done_o = v_q[4];
  assign hit_o  = hit_q;
endmodule
`default_nettype wire

[rtl/gbs_back.sv]
// Back end: stores candidates, picks them in score order, runs the
// overlap tests against kept boxes and emits the kept list.
// Depends on gbs_pkg, gbs_ram, gbs_iou.
`default_nettype none
module gbs_back
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_CANDIDATES = MaxCandidates,
  parameter int unsigned MAX_KEPT       = MaxKept
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] thr_i,
  input  wire logic        q_valid_i,
  output logic             q_pop_o,
  input  wire cand_t       q_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output box_out_t         out_data_o
);
  localparam int unsigned CW   = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned IW   = $clog2(MAX_CANDIDATES);
  localparam int unsigned KCW  = $clog2(MAX_KEPT + 1);
  localparam int unsigned KIW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d, picks_q, picks_d, scan_q, scan_d;
  logic [MAX_CANDIDATES-1:0] done_q, done_d;
  logic [KCW-1:0]            kc_q, kc_d, k_q, k_d, e_q, e_d;
  logic                      rd_vld_q, rd_vld_d, best_v_q, best_v_d;
  logic                      busy_q, busy_d, out_v_q, out_v_d;
  logic [IW-1:0]             rd_idx_q, rd_idx_d, best_idx_q, best_idx_d;
  logic [15:0]               best_score_q, best_score_d;
  logic [63:0]               best_geom_q, best_geom_d;
  logic [63:0]               kg_q [MAX_KEPT];
  logic [15:0]               ks_q [MAX_KEPT];
  logic                      kept_we;
  box_out_t                  out_q, out_d;

  logic          ram_we;
  logic [IW-1:0] raddr;
  logic [79:0]   rdata;
  logic          iou_start, iou_done, iou_hit;
  logic          load, last;

  gbs_ram #(
    .W (80),
    .D (MAX_CANDIDATES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({q_data_i.score, q_data_i.geom}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gbs_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iou_start),
    .a_i     (best_geom_q),
    .b_i     (kg_q[k_q[KIW-1:0]]),
    .thr_i   (thr_i),
    .done_o  (iou_done),
    .hit_o   (iou_hit)
  );

  assign q_pop_o     = (state_q == ST_LOAD);
  assign ram_we      = q_pop_o && q_valid_i && q_data_i.store;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    picks_d      = picks_q;
    scan_d       = scan_q;
    done_d       = done_q;
    kc_d         = kc_q;
    k_d          = k_q;
    e_d          = e_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    best_v_d     = best_v_q;
    best_idx_d   = best_idx_q;
    best_score_d = best_score_q;
    best_geom_d  = best_geom_q;
    busy_d       = busy_q;
    raddr        = scan_q[IW-1:0];
    iou_start    = 1'b0;
    kept_we      = 1'b0;
    load         = 1'b0;
    last         = 1'b0;
    out_d        = out_q;
    out_v_d      = out_v_q && !out_ready_i;

    unique case (state_q)
      ST_LOAD: begin
        if (q_valid_i) begin
          if (q_data_i.store) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (q_data_i.frame_end) begin
            picks_d  = '0;
            kc_d     = '0;
            e_d      = '0;
            scan_d   = '0;
            best_v_d = 1'b0;
            state_d  = (cnt_d == '0) ? ST_EMIT : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q < cnt_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IW-1:0];
          scan_d   = scan_q + 1'b1;
        end
        if (rd_vld_q && !done_q[rd_idx_q] &&
            (!best_v_q || rdata[79:64] > best_score_q)) begin
          best_v_d     = 1'b1;
          best_idx_d   = rd_idx_q;
          best_score_d = rdata[79:64];
          best_geom_d  = rdata[63:0];
        end
        if (scan_q == cnt_q && !rd_vld_q) begin
          done_d[best_idx_q] = 1'b1;
          picks_d = picks_q + 1'b1;
          k_d     = '0;
          busy_d  = 1'b0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (k_q == kc_q) begin
          kept_we = 1'b1;
          kc_d    = kc_q + 1'b1;
        end else if (!busy_q) begin
          iou_start = 1'b1;
          busy_d    = 1'b1;
        end else if (iou_done) begin
          busy_d = 1'b0;
          if (!iou_hit) begin
            k_d = k_q + 1'b1;
          end
        end
        if (kept_we || (busy_q && iou_done && iou_hit)) begin
          scan_d   = '0;
          best_v_d = 1'b0;
          e_d      = '0;
          state_d  = (kc_d == KCW'(MAX_KEPT) || picks_q == cnt_q) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (!out_v_q || out_ready_i) begin
          load    = 1'b1;
          out_v_d = 1'b1;
          if (kc_q == '0) begin
            out_d = '0;
            out_d.last_result = 1'b1;
            last = 1'b1;
          end else begin
            last = (e_q == kc_q - 1'b1);
            out_d.kept_left    = kg_q[e_q[KIW-1:0]][15:0];
            out_d.kept_top     = kg_q[e_q[KIW-1:0]][31:16];
            out_d.kept_span_x  = kg_q[e_q[KIW-1:0]][47:32];
            out_d.kept_span_y  = kg_q[e_q[KIW-1:0]][63:48];
            out_d.kept_score   = ks_q[e_q[KIW-1:0]];
            out_d.person_found = 1'b1;
            out_d.last_result  = last;
            e_d = e_q + 1'b1;
          end
          if (last) begin
            cnt_d   = '0;
            done_d  = '0;
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      picks_q  <= '0;
      scan_q   <= '0;
      done_q   <= '0;
      kc_q     <= '0;
      k_q      <= '0;
      e_q      <= '0;
      rd_vld_q <= 1'b0;
      best_v_q <= 1'b0;
      busy_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      picks_q  <= picks_d;
      scan_q   <= scan_d;
      done_q   <= done_d;
      kc_q     <= kc_d;
      k_q      <= k_d;
      e_q      <= e_d;
      rd_vld_q <= rd_vld_d;
      best_v_q <= best_v_d;
      busy_q   <= busy_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_score_q <= best_score_d;
    best_geom_q  <= best_geom_d;
    if (load) begin
      out_q <= out_d;
    end
    if (kept_we) begin
      kg_q[kc_q[KIW-1:0]] <= best_geom_q;
      ks_q[kc_q[KIW-1:0]] <= best_score_q;
    end
  end
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for greedy_box_suppression: random and directed frames of boxes,
// predicted in-bench (stable score sort, greedy overlap suppression). Depends on gbs_pkg.
`default_nettype none
module tb;
  import gbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  box_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  box_out_t out_data_o;
  logic cfg_we_i;
  logic [15:0] cfg_data_i;

  greedy_box_suppression dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  logic [63:0] frame_geom [MaxCandidates];
  logic [15:0] frame_score [MaxCandidates];
  int unsigned frame_count;
  logic [15:0] iou_thr;
  box_out_t expected_kept [$];
  int unsigned errors;
  int unsigned cycles;
  bit calm;

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic bit overlap_reaches(logic [63:0] a, logic [63:0] b);
    logic [63:0] al, at, aw, ah, bl, bt, bw, bh, l, t, r, bo, iw, ih, inter, uni;
    al = 64'(a[15:0]); at = 64'(a[31:16]); aw = 64'(a[47:32]); ah = 64'(a[63:48]);
    bl = 64'(b[15:0]); bt = 64'(b[31:16]); bw = 64'(b[47:32]); bh = 64'(b[63:48]);
    l = al > bl ? al : bl;
    t = at > bt ? at : bt;
    r = (al + aw) < (bl + bw) ? al + aw : bl + bw;
    bo = (at + ah) < (bt + bh) ? at + ah : bt + bh;
    iw = r > l ? r - l : 64'd0;
    ih = bo > t ? bo - t : 64'd0;
    inter = iw * ih;
    uni = aw * ah + bw * bh - inter;
    if (uni == 0) return iou_thr == 0;
    return (inter << 16) >= 64'(iou_thr) * uni;
  endfunction

  task automatic predict_item(box_in_t b);
    int unsigned order [MaxCandidates];
    logic [63:0] kg [MaxKept];
    logic [15:0] ks [MaxKept];
    int unsigned nk, j;
    bit dup;
    box_out_t o;
    if (b.box_present && frame_count < MaxCandidates) begin
      frame_geom[frame_count] = {b.box_span_y, b.box_span_x, b.box_top, b.box_left};
      frame_score[frame_count] = b.box_score;
      frame_count++;
    end
    if (!b.frame_end) return;
    for (int unsigned i = 0; i < frame_count; i++) begin
      j = i;
      while (j > 0 && frame_score[order[j-1]] < frame_score[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    nk = 0;
    for (int unsigned i = 0; i < frame_count && nk < MaxKept; i++) begin
      dup = 0;
      for (int unsigned k = 0; k < nk; k++)
        if (overlap_reaches(frame_geom[order[i]], kg[k])) dup = 1;
      if (!dup) begin
        kg[nk] = frame_geom[order[i]];
        ks[nk] = frame_score[order[i]];
        nk++;
      end
    end
    frame_count = 0;
    if (nk == 0) begin
      o = '0;
      o.last_result = 1'b1;
      expected_kept.push_back(o);
    end
    for (int unsigned k = 0; k < nk; k++) begin
      o.kept_left = kg[k][15:0];
      o.kept_top = kg[k][31:16];
      o.kept_span_x = kg[k][47:32];
      o.kept_span_y = kg[k][63:48];
      o.kept_score = ks[k];
      o.person_found = 1'b1;
      o.last_result = (k + 1 == nk);
      expected_kept.push_back(o);
    end
  endtask

  task automatic send_item(box_in_t b);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_kept.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    iou_thr = v;
  endtask

  function automatic box_in_t make_box(bit clustered, bit fe);
    box_in_t b;
    logic [15:0] cx, cy;
    if (clustered) begin
      cx = 16'($urandom_range(3) * 15000 + 2000);
      cy = 16'($urandom_range(3) * 15000 + 2000);
      b.box_left = cx + 16'($urandom_range(1500));
      b.box_top = cy + 16'($urandom_range(1500));
      b.box_span_x = 16'($urandom_range(12000, 2000));
      b.box_span_y = 16'($urandom_range(12000, 2000));
      b.box_score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 20000)
                                             : 16'($urandom);
    end else begin
      b.box_left = 16'($urandom);
      b.box_top = 16'($urandom);
      b.box_span_x = 16'($urandom);
      b.box_span_y = 16'($urandom);
      b.box_score = 16'($urandom);
    end
    b.box_present = ($urandom_range(9) != 0);
    b.frame_end = fe;
    return b;
  endfunction

  function automatic box_in_t box_of(int l, int t, int w, int h, int s, bit p, bit fe);
    box_in_t b;
    b = '{16'(l), 16'(t), 16'(w), 16'(h), 16'(s), p, fe};
    return b;
  endfunction

  // checker
  always @(posedge clk_i) begin
    box_out_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_kept.size() == 0) begin
        report("unexpected result", out_data_o.kept_score, 16'd0);
      end else begin
        want = expected_kept.pop_front();
        if (out_data_o.kept_left !== want.kept_left)
          report("kept_left", out_data_o.kept_left, want.kept_left);
        if (out_data_o.kept_top !== want.kept_top)
          report("kept_top", out_data_o.kept_top, want.kept_top);
        if (out_data_o.kept_span_x !== want.kept_span_x)
          report("kept_span_x", out_data_o.kept_span_x, want.kept_span_x);
        if (out_data_o.kept_span_y !== want.kept_span_y)
          report("kept_span_y", out_data_o.kept_span_y, want.kept_span_y);
        if (out_data_o.kept_score !== want.kept_score)
          report("kept_score", out_data_o.kept_score, want.kept_score);
        if (out_data_o.person_found !== want.person_found)
          report("person_found", 16'(out_data_o.person_found), 16'(want.person_found));
        if (out_data_o.last_result !== want.last_result)
          report("last_result", 16'(out_data_o.last_result), 16'(want.last_result));
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 21);
  end

  task automatic test_directed();
    // reset threshold: two identical boxes and a half-overlapping one, tie scores
    send_item(box_of(0, 0, 1000, 1000, 500, 1, 0));
    send_item(box_of(0, 0, 1000, 1000, 500, 1, 0));
    send_item(box_of(500, 0, 1000, 1000, 500, 1, 0));
    send_item(box_of(0, 0, 0, 0, 65535, 1, 1));
    // empty frame
    send_item(box_of(0, 0, 0, 0, 0, 0, 1));
    // edges past the frame
    send_item(box_of(65535, 65535, 65535, 65535, 65535, 1, 0));
    send_item(box_of(65535, 65535, 65535, 65535, 0, 1, 1));
    write_threshold(16'd0);
    // threshold zero: the first pick suppresses every other box, zero-area ones too
    send_item(box_of(100, 100, 0, 0, 10, 1, 0));
    send_item(box_of(40000, 40000, 0, 5, 20, 1, 0));
    send_item(box_of(0, 0, 1, 1, 30, 1, 1));
    write_threshold(16'hFFFF);
    send_item(box_of(0, 0, 65535, 65535, 1, 1, 0));
    send_item(box_of(0, 0, 65535, 65535, 2, 1, 0));
    send_item(box_of(0, 0, 0, 0, 3, 1, 0));
    send_item(box_of(0, 0, 0, 0, 3, 0, 1));
    write_threshold(16'd1);
    send_item(box_of(0, 0, 0, 0, 7, 1, 0));
    send_item(box_of(0, 0, 0, 0, 7, 1, 0));
    send_item(box_of(1, 1, 100, 100, 9, 1, 0));
    send_item(box_of(101, 101, 100, 100, 9, 1, 1));
  endtask

  task automatic test_store_full();
    box_in_t b;
    write_threshold(16'd20000);
    for (int i = 0; i < 36; i++) begin
      b = make_box(1, i == 35);
      b.box_present = 1'b1;
      send_item(b);
    end
  endtask

  task automatic test_random_frames(int unsigned items, logic [15:0] thr);
    int unsigned sent, len;
    write_threshold(thr);
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(36, 30) : $urandom_range(12, 1);
      for (int unsigned i = 0; i < len; i++) send_item(make_box(1, i + 1 == len));
      sent += len;
      if ($urandom_range(9) == 0) drain();
    end
  endtask

  task automatic test_noise(int unsigned items);
    box_in_t b;
    write_threshold(16'($urandom));
    for (int unsigned i = 0; i < items; i++) begin
      b = make_box(0, $urandom_range(5) == 0 || i + 1 == items);
      b.box_present = 1'($urandom_range(1));
      send_item(b);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    out_ready_i = 1'b0;
    frame_count = 0;
    iou_thr = IouThrReset;
    errors = 0;
    cycles = 0;
    calm = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random_frames(90, 16'd32768);
    calm = 1;
    test_random_frames(60, 16'd8000);
    calm = 0;
    test_random_frames(50, 16'd0);
    test_random_frames(50, 16'hFFFF);
    test_random_frames(40, 16'($urandom));
    test_noise(40);
    drain();
    if (errors == 0 && expected_kept.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
